// ===== design/gne_pkg.sv =====
package gne_pkg;

  localparam int TABLE_DEPTH_DEF = 514;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int GRAD_W  = 16;
  localparam int PERM_W  = 8;
  localparam int CELL_W  = 8;
  localparam int INDEX_W = 10;
  localparam int NOISE_W = 20;
  localparam int LAT_W   = 9;
  localparam int CORNERS = 8;

  localparam logic [LAT_W-1:0] LATTICE_RESET = 9'd4;

  // Item kinds carried in the input tuser.
  localparam logic [1:0] FUNC_LOAD_PERM = 2'd0;
  localparam logic [1:0] FUNC_LOAD_G2   = 2'd1;
  localparam logic [1:0] FUNC_LOAD_G3   = 2'd2;
  localparam logic [1:0] FUNC_EVAL      = 2'd3;

  // Evaluation modes after dims has been cleaned up.
  localparam logic [1:0] MODE_1D = 2'd1;
  localparam logic [1:0] MODE_2D = 2'd2;
  localparam logic [1:0] MODE_3D = 2'd3;

  // Register word select (paddr bit 2).
  localparam logic REG_LATTICE = 1'b0;

  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] func;
    logic [1:0] mode;
  } ctl_t;

endpackage

// ===== design/gne_ram.sv =====
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== design/gne_scurve.sv =====
module gne_scurve
  import gne_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] frac [3],
  output logic [FRAC_BITS+1:0] s [3]
);

  localparam int F = FRAC_BITS;
  localparam logic [F+1:0] THREE = (F+2)'(3) << F;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [F-1:0]   t;
    logic [F-1:0]   t2;
    logic [F+1:0]   k;
    logic [2*F-1:0] sq;
    logic [2*F+1:0] pr;

    assign sq = t * t;
    assign pr = t2 * k;

    always_ff @(posedge clk) begin
      if (en) begin
        t    <= frac[l];
        t2   <= sq[2*F-1:F];
        k    <= THREE - {1'b0, t, 1'b0};
        s[l] <= pr[2*F+1:F];
      end
    end
  end

endmodule

// ===== design/gne_lookup.sv =====
module gne_lookup
  import gne_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  ctl_t                  ctl1,
  input  ctl_t                  ctl2,
  input  ctl_t                  ctl3,
  input  logic [CELL_W-1:0]     mask,
  input  logic [31:0]           coord_x,
  input  logic [31:0]           coord_y,
  input  logic [31:0]           coord_z,
  input  logic [INDEX_W-1:0]    table_index,
  input  logic [PERM_W-1:0]     perm_value,
  input  grad_t                 grad_a,
  input  grad_t                 grad_b,
  input  grad_t                 grad_c,
  output logic [FRAC_BITS-1:0]  frac_x,
  output logic [FRAC_BITS-1:0]  frac_y,
  output logic [FRAC_BITS-1:0]  frac_z,
  output grad_t                 g1 [2],
  output logic [2*GRAD_W-1:0]   g2 [4],
  output logic [3*GRAD_W-1:0]   g3 [CORNERS]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int F  = FRAC_BITS;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [PERM_W-1:0]  pv;
    grad_t              ga;
    grad_t              gb;
    grad_t              gc;
  } ld_t;

  // Cell indices straight from the coordinates. The lattice offset has
  // zero low byte, so it drops out under an 8-bit mask.
  logic [CELL_W-1:0] bx0_in, bx1_in, by0_in, by1_in, bz0_in, bz1_in;

  assign bx0_in = coord_x[F +: CELL_W] & mask;
  assign by0_in = coord_y[F +: CELL_W] & mask;
  assign bz0_in = coord_z[F +: CELL_W] & mask;
  assign bx1_in = (bx0_in + CELL_W'(1)) & mask;
  assign by1_in = (by0_in + CELL_W'(1)) & mask;
  assign bz1_in = (bz0_in + CELL_W'(1)) & mask;

  // Stage 1
  logic [CELL_W-1:0] r1_bx0, r1_bx1, r1_by0, r1_by1, r1_bz0, r1_bz1;
  logic [F-1:0]      r1_fx, r1_fy, r1_fz;
  ld_t               ld1;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_bx0 <= bx0_in;
      r1_bx1 <= bx1_in;
      r1_by0 <= by0_in;
      r1_by1 <= by1_in;
      r1_bz0 <= bz0_in;
      r1_bz1 <= bz1_in;
      r1_fx  <= coord_x[F-1:0];
      r1_fy  <= coord_y[F-1:0];
      r1_fz  <= coord_z[F-1:0];
      ld1    <= '{idx: table_index, pv: perm_value, ga: grad_a, gb: grad_b, gc: grad_c};
    end
  end

  logic [PERM_W-1:0] p1_rd0, p1_rd1;
  logic              we_p1;

  assign we_p1 = ctl1.vld && (ctl1.func == FUNC_LOAD_PERM) && (int'(ld1.idx) < TABLE_DEPTH);

  gne_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_DEPTH)) u_perm1 (
    .clk    (clk),
    .en     (en),
    .we     (we_p1),
    .waddr  (AW'(ld1.idx)),
    .wdata  (ld1.pv),
    .raddr0 (AW'(r1_bx0)),
    .raddr1 (AW'(r1_bx1)),
    .rdata0 (p1_rd0),
    .rdata1 (p1_rd1)
  );

  // Stage 2
  logic              r2_oob_i, r2_oob_j;
  logic [CELL_W-1:0] r2_by0, r2_by1, r2_bz0, r2_bz1;
  logic [F-1:0]      r2_fx, r2_fy, r2_fz;
  ld_t               ld2;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_oob_i <= int'(r1_bx0) >= TABLE_DEPTH;
      r2_oob_j <= int'(r1_bx1) >= TABLE_DEPTH;
      r2_by0   <= r1_by0;
      r2_by1   <= r1_by1;
      r2_bz0   <= r1_bz0;
      r2_bz1   <= r1_bz1;
      r2_fx    <= r1_fx;
      r2_fy    <= r1_fy;
      r2_fz    <= r1_fz;
      ld2      <= ld1;
    end
  end

  logic [PERM_W-1:0] pi, pj;
  logic [CELL_W:0]   pa [4];
  logic              we_p2;

  assign pi = r2_oob_i ? '0 : p1_rd0;
  assign pj = r2_oob_j ? '0 : p1_rd1;

  // Corner order: (i,y0), (j,y0), (i,y1), (j,y1).
  assign pa[0] = {1'b0, pi} + {1'b0, r2_by0};
  assign pa[1] = {1'b0, pj} + {1'b0, r2_by0};
  assign pa[2] = {1'b0, pi} + {1'b0, r2_by1};
  assign pa[3] = {1'b0, pj} + {1'b0, r2_by1};

  assign we_p2 = ctl2.vld && (ctl2.func == FUNC_LOAD_PERM) && (int'(ld2.idx) < TABLE_DEPTH);

  logic [PERM_W-1:0] p2_rd [4];
  grad_t             g1_rd [2];

  for (genvar m = 0; m < 2; m++) begin : g_perm2
    gne_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_DEPTH)) u_perm2 (
      .clk    (clk),
      .en     (en),
      .we     (we_p2),
      .waddr  (AW'(ld2.idx)),
      .wdata  (ld2.pv),
      .raddr0 (AW'(pa[2*m])),
      .raddr1 (AW'(pa[2*m+1])),
      .rdata0 (p2_rd[2*m]),
      .rdata1 (p2_rd[2*m+1])
    );
  end

  gne_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_DEPTH)) u_grad1 (
    .clk    (clk),
    .en     (en),
    .we     (we_p2),
    .waddr  (AW'(ld2.idx)),
    .wdata  (ld2.ga),
    .raddr0 (AW'(pi)),
    .raddr1 (AW'(pj)),
    .rdata0 (g1_rd[0]),
    .rdata1 (g1_rd[1])
  );

  // Stage 3
  logic              r3_oob_b [4];
  logic              r3_oob_g1 [2];
  logic [CELL_W-1:0] r3_bz0, r3_bz1;
  logic [F-1:0]      r3_fx, r3_fy, r3_fz;
  ld_t               ld3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r3_oob_b[k] <= int'(pa[k]) >= TABLE_DEPTH;
      end
      r3_oob_g1[0] <= int'(pi) >= TABLE_DEPTH;
      r3_oob_g1[1] <= int'(pj) >= TABLE_DEPTH;
      r3_bz0 <= r2_bz0;
      r3_bz1 <= r2_bz1;
      r3_fx  <= r2_fx;
      r3_fy  <= r2_fy;
      r3_fz  <= r2_fz;
      ld3    <= ld2;
    end
  end

  logic [PERM_W-1:0] bb [4];
  logic [CELL_W:0]   ca [CORNERS];
  logic              we_g2, we_g3;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bb[k] = r3_oob_b[k] ? '0 : p2_rd[k];
    end
    for (int k = 0; k < CORNERS; k++) begin
      ca[k] = {1'b0, bb[k % 4]} + {1'b0, (k < 4) ? r3_bz0 : r3_bz1};
    end
  end

  assign we_g2 = ctl3.vld && (ctl3.func == FUNC_LOAD_G2) && (int'(ld3.idx) < TABLE_DEPTH);
  assign we_g3 = ctl3.vld && (ctl3.func == FUNC_LOAD_G3) && (int'(ld3.idx) < TABLE_DEPTH);

  logic [2*GRAD_W-1:0] g2_rd [4];
  logic [3*GRAD_W-1:0] g3_rd [CORNERS];

  for (genvar m = 0; m < 2; m++) begin : g_grad2
    gne_ram #(.WIDTH(2*GRAD_W), .DEPTH(TABLE_DEPTH)) u_grad2 (
      .clk    (clk),
      .en     (en),
      .we     (we_g2),
      .waddr  (AW'(ld3.idx)),
      .wdata  ({ld3.gb, ld3.ga}),
      .raddr0 (AW'(bb[2*m])),
      .raddr1 (AW'(bb[2*m+1])),
      .rdata0 (g2_rd[2*m]),
      .rdata1 (g2_rd[2*m+1])
    );
  end

  for (genvar m = 0; m < 4; m++) begin : g_grad3
    gne_ram #(.WIDTH(3*GRAD_W), .DEPTH(TABLE_DEPTH)) u_grad3 (
      .clk    (clk),
      .en     (en),
      .we     (we_g3),
      .waddr  (AW'(ld3.idx)),
      .wdata  ({ld3.gc, ld3.gb, ld3.ga}),
      .raddr0 (AW'(ca[2*m])),
      .raddr1 (AW'(ca[2*m+1])),
      .rdata0 (g3_rd[2*m]),
      .rdata1 (g3_rd[2*m+1])
    );
  end

  // Stage 4
  logic  r4_oob_g2 [4];
  logic  r4_oob_g3 [CORNERS];
  grad_t r4_g1 [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r4_oob_g2[k] <= int'(bb[k]) >= TABLE_DEPTH;
      end
      for (int k = 0; k < CORNERS; k++) begin
        r4_oob_g3[k] <= int'(ca[k]) >= TABLE_DEPTH;
      end
      for (int k = 0; k < 2; k++) begin
        r4_g1[k] <= r3_oob_g1[k] ? '0 : g1_rd[k];
      end
      frac_x <= r3_fx;
      frac_y <= r3_fy;
      frac_z <= r3_fz;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      g1[k] = r4_g1[k];
    end
    for (int k = 0; k < 4; k++) begin
      g2[k] = r4_oob_g2[k] ? '0 : g2_rd[k];
    end
    for (int k = 0; k < CORNERS; k++) begin
      g3[k] = r4_oob_g3[k] ? '0 : g3_rd[k];
    end
  end

endmodule

// ===== design/gne_dot.sv =====
module gne_dot
  import gne_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [1:0]                   mode,
  input  logic [FRAC_BITS-1:0]         frac_x,
  input  logic [FRAC_BITS-1:0]         frac_y,
  input  logic [FRAC_BITS-1:0]         frac_z,
  input  grad_t                        g1 [2],
  input  logic [2*GRAD_W-1:0]          g2 [4],
  input  logic [3*GRAD_W-1:0]          g3 [CORNERS],
  output logic signed [FRAC_BITS+5:0]  dot [CORNERS]
);

  localparam int F  = FRAC_BITS;
  localparam int RW = F + 2;
  localparam int PW = RW + GRAD_W;
  localparam int VW = F + 6;
  localparam logic signed [RW-1:0] ONE = RW'(2**F);

  logic signed [RW-1:0] rx0, rx1, ry0, ry1, rz0, rz1;

  assign rx0 = $signed({2'b00, frac_x});
  assign ry0 = $signed({2'b00, frac_y});
  assign rz0 = $signed({2'b00, frac_z});
  assign rx1 = rx0 - ONE;
  assign ry1 = ry0 - ONE;
  assign rz1 = rz0 - ONE;

  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    grad_t                gx, gy, gz;
    logic signed [RW-1:0] rx, ry, rz;
    logic signed [PW-1:0] px, py, pz;

    assign rx = (c % 2 == 1) ? rx1 : rx0;
    assign ry = ((c / 2) % 2 == 1) ? ry1 : ry0;
    assign rz = (c / 4 == 1) ? rz1 : rz0;

    // Unused components read as zero, so every mode runs the same adder.
    always_comb begin
      gx = '0;
      gy = '0;
      gz = '0;
      case (mode)
        MODE_3D: begin
          gx = g3[c][GRAD_W-1:0];
          gy = g3[c][2*GRAD_W-1:GRAD_W];
          gz = g3[c][3*GRAD_W-1:2*GRAD_W];
        end
        MODE_2D: begin
          if (c < 4) begin
            gx = g2[c % 4][GRAD_W-1:0];
            gy = g2[c % 4][2*GRAD_W-1:GRAD_W];
          end
        end
        default: begin
          if (c < 2) begin
            gx = g1[c % 2];
          end
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        px     <= rx * gx;
        py     <= ry * gy;
        pz     <= rz * gz;
        dot[c] <= VW'(px >>> (GRAD_W - 1)) + VW'(py >>> (GRAD_W - 1))
                + VW'(pz >>> (GRAD_W - 1));
      end
    end
  end

endmodule

// ===== design/gne_lerp.sv =====
module gne_lerp
  import gne_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int LANES     = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS+1:0]        s,
  input  logic signed [FRAC_BITS+5:0] a [LANES],
  input  logic signed [FRAC_BITS+5:0] b [LANES],
  output logic signed [FRAC_BITS+5:0] y [LANES]
);

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 6;
  localparam int DW = VW + 1;
  localparam int PW = DW + F + 3;

  logic signed [F+2:0] ss;

  assign ss = $signed({1'b0, s});

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sum;
    logic signed [VW-1:0] ah;

    assign diff = DW'(b[l]) - DW'(a[l]);
    assign sum  = PW'(ah) + (prod >>> F);

    always_ff @(posedge clk) begin
      if (en) begin
        prod <= ss * diff;
        ah   <= a[l];
        y[l] <= sum[VW-1:0];
      end
    end
  end

endmodule

// ===== design/gradient_noise_evaluator_core.sv =====
// Throughput: one item per cycle while the output is not stalled; the tables
// are read in successive pipeline stages from replicated one-write, two-read
// memories, so no port is shared between items.
// A stalled output freezes the whole pipeline; the input is ready whenever it moves.
// Reset (synchronous, active high) clears all valid bits and sets lattice_size to 4;
// table contents are not cleared and must be loaded before use.
module gradient_noise_evaluator_core
  import gne_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // dims[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66], table_index[107:98],
  // perm_value[115:108], grad_a[131:116], grad_b[147:132], grad_c[163:148], zero pad
  input  logic [167:0] s_tdata,
  // func[1:0]
  input  logic [1:0]   s_tuser,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // noise_value[19:0], zero pad
  output logic [23:0]  m_tdata,
  // was_evaluate[0]
  output logic [0:0]   m_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAT = 13;
  localparam int F   = FRAC_BITS;
  localparam int SW  = F + 2;
  localparam int VW  = F + 6;
  localparam int XW  = (VW > NOISE_W) ? VW : NOISE_W + 1;
  localparam logic signed [XW-1:0] SAT_HI = XW'((2**(NOISE_W-1)) - 1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  // ---------------------------------------------------------------------------
  // Configuration register. Writes land on the access cycle of an APB transfer.
  // ---------------------------------------------------------------------------
  logic [LAT_W-1:0] lattice_size;
  logic [LAT_W-1:0] lat_m1;
  logic [CELL_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size <= LATTICE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LATTICE)) begin
      lattice_size <= pwdata[LAT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LATTICE) ? {{(32-LAT_W){1'b0}}, lattice_size} : '0;

  // Only the low byte of lattice_size-1 masks the cell index, so sizes 0 and 256
  // both give the full 256-cell period.
  assign lat_m1 = lattice_size - LAT_W'(1);
  assign mask   = lat_m1[CELL_W-1:0];

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage advances together; a result held on the
  // output blocks the pipe only while it is not taken.
  // ---------------------------------------------------------------------------
  logic en;
  ctl_t ctl [1:LAT];
  ctl_t in_ctl;

  logic [1:0]          in_dims;
  logic [31:0]         in_x, in_y, in_z;
  logic [INDEX_W-1:0]  in_idx;
  logic [PERM_W-1:0]   in_pv;
  grad_t               in_ga, in_gb, in_gc;

  assign in_dims = s_tdata[1:0];
  assign in_x    = s_tdata[33:2];
  assign in_y    = s_tdata[65:34];
  assign in_z    = s_tdata[97:66];
  assign in_idx  = s_tdata[107:98];
  assign in_pv   = s_tdata[115:108];
  assign in_ga   = s_tdata[131:116];
  assign in_gb   = s_tdata[147:132];
  assign in_gc   = s_tdata[163:148];

  assign en       = !ctl[LAT].vld || m_tready;
  assign s_tready = en;

  // A dims of zero evaluates as one dimension.
  always_comb begin
    in_ctl.vld  = s_tvalid;
    in_ctl.func = s_tuser;
    case (in_dims)
      2'd3:    in_ctl.mode = MODE_3D;
      2'd2:    in_ctl.mode = MODE_2D;
      default: in_ctl.mode = MODE_1D;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) begin
        ctl[k] <= '0;
      end
    end else if (en) begin
      ctl[1] <= in_ctl;
      for (int k = 2; k <= LAT; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-4: cell split and table lookups. Loads write each table in the
  // same stage in which evaluations read it, so program order is kept.
  // ---------------------------------------------------------------------------
  logic [F-1:0]        fx4, fy4, fz4;
  grad_t               g1 [2];
  logic [2*GRAD_W-1:0] g2 [4];
  logic [3*GRAD_W-1:0] g3 [CORNERS];

  gne_lookup #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_lookup (
    .clk         (clk),
    .en          (en),
    .ctl1        (ctl[1]),
    .ctl2        (ctl[2]),
    .ctl3        (ctl[3]),
    .mask        (mask),
    .coord_x     (in_x),
    .coord_y     (in_y),
    .coord_z     (in_z),
    .table_index (in_idx),
    .perm_value  (in_pv),
    .grad_a      (in_ga),
    .grad_b      (in_gb),
    .grad_c      (in_gc),
    .frac_x      (fx4),
    .frac_y      (fy4),
    .frac_z      (fz4),
    .g1          (g1),
    .g2          (g2),
    .g3          (g3)
  );

  // ---------------------------------------------------------------------------
  // Stages 1-3: s-curve of each fraction, in parallel with the lookups.
  // ---------------------------------------------------------------------------
  logic [F-1:0]  sc_frac [3];
  logic [SW-1:0] sc_s [3];

  assign sc_frac[0] = in_x[F-1:0];
  assign sc_frac[1] = in_y[F-1:0];
  assign sc_frac[2] = in_z[F-1:0];

  gne_scurve #(.FRAC_BITS(FRAC_BITS)) u_scurve (
    .clk  (clk),
    .en   (en),
    .frac (sc_frac),
    .s    (sc_s)
  );

  // Blend weights follow the item down to their lerp level. For fewer
  // dimensions the upper weights are forced to zero, which makes those levels
  // pass their first operand through, so the last level always holds the answer.
  typedef struct packed {
    logic [SW-1:0] x;
    logic [SW-1:0] y;
    logic [SW-1:0] z;
  } svec_t;

  svec_t sdel [4:10];
  svec_t s_in;

  always_comb begin
    s_in.x = sc_s[0];
    s_in.y = (ctl[3].mode == MODE_2D || ctl[3].mode == MODE_3D) ? sc_s[1] : '0;
    s_in.z = (ctl[3].mode == MODE_3D) ? sc_s[2] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdel[4] <= s_in;
      for (int k = 5; k <= 10; k++) begin
        sdel[k] <= sdel[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5-6: gradient products and corner dot products.
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] dot [CORNERS];

  gne_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk    (clk),
    .en     (en),
    .mode   (ctl[4].mode),
    .frac_x (fx4),
    .frac_y (fy4),
    .frac_z (fz4),
    .g1     (g1),
    .g2     (g2),
    .g3     (g3),
    .dot    (dot)
  );

  // ---------------------------------------------------------------------------
  // Stages 7-12: three lerp levels along x, y and z, two stages each.
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] l1_a [4], l1_b [4], l1_y [4];
  logic signed [VW-1:0] l2_a [2], l2_b [2], l2_y [2];
  logic signed [VW-1:0] l3_a [1], l3_b [1], l3_y [1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      l1_a[k] = dot[2*k];
      l1_b[k] = dot[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      l2_a[k] = l1_y[2*k];
      l2_b[k] = l1_y[2*k+1];
    end
    l3_a[0] = l2_y[0];
    l3_b[0] = l2_y[1];
  end

  gne_lerp #(.FRAC_BITS(FRAC_BITS), .LANES(4)) u_lerp_x (
    .clk (clk), .en (en), .s (sdel[6].x), .a (l1_a), .b (l1_b), .y (l1_y)
  );

  gne_lerp #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_lerp_y (
    .clk (clk), .en (en), .s (sdel[8].y), .a (l2_a), .b (l2_b), .y (l2_y)
  );

  gne_lerp #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_lerp_z (
    .clk (clk), .en (en), .s (sdel[10].z), .a (l3_a), .b (l3_b), .y (l3_y)
  );

  // ---------------------------------------------------------------------------
  // Stage 13: saturate to the output range; load acknowledges carry zero.
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0]  wide;
  logic [NOISE_W-1:0]    sat;
  logic [NOISE_W-1:0]    out_noise;

  assign wide = XW'(l3_y[0]);

  always_comb begin
    if (wide > SAT_HI) begin
      sat = SAT_HI[NOISE_W-1:0];
    end else if (wide < SAT_LO) begin
      sat = SAT_LO[NOISE_W-1:0];
    end else begin
      sat = wide[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise <= (ctl[LAT-1].func == FUNC_EVAL) ? sat : '0;
    end
  end

  assign m_tvalid   = ctl[LAT].vld;
  assign m_tdata    = {{(24-NOISE_W){1'b0}}, out_noise};
  assign m_tuser[0] = (ctl[LAT].func == FUNC_EVAL);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ctl[6]) && $stable(ctl[12]))
    else $error("pipeline moved during an output stall");

  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    en && ctl[LAT-1].vld |=> m_tvalid)
    else $error("item lost between last stage and output");

  a_load_ack_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> out_noise == '0)
    else $error("load acknowledge carries a nonzero value");

  a_lattice_reset: assert property (@(posedge clk)
    $past(rst) |-> lattice_size == LATTICE_RESET)
    else $error("lattice_size not at its reset value after reset");

endmodule
